### rtl/apr_pkg.sv
// Package for the box push-out resolver: command and register codes,
// the box table word, the sequencer step codes and the control group.
// No dependencies.
`timescale 1ns / 1ps

package apr_pkg;

    localparam int POS_W = 32;
    localparam int EXT_W = 21;
    localparam int DW    = 36;
    localparam int EPS_Q = 66;

    localparam logic [1:0] CMD_APPEND  = 2'd0;
    localparam logic [1:0] CMD_CLEAR   = 2'd1;
    localparam logic [1:0] CMD_RESOLVE = 2'd2;

    localparam logic [0:0] REG_RADIUS = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

    localparam logic [EXT_W-1:0] RADIUS_RESET = 21'd19661;
    localparam logic [EXT_W-1:0] HEIGHT_RESET = 21'd117965;

    typedef struct packed {
        logic signed [POS_W-1:0] centre_x;
        logic signed [POS_W-1:0] bottom_y;
        logic signed [POS_W-1:0] centre_z;
        logic [EXT_W-1:0]        extent_x;
        logic [EXT_W-1:0]        extent_z;
        logic [EXT_W-1:0]        extent_y;
    } box_t;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_FETCH = 8'b0000_0010,
        ST_BOUND = 8'b0000_0100,
        ST_SPAN  = 8'b0000_1000,
        ST_OVLP  = 8'b0001_0000,
        ST_PICK  = 8'b0010_0000,
        ST_MOVE  = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } step_t;

    typedef struct packed {
        step_t step;
        logic  load;
    } ctrl_t;

endpackage

### rtl/apr_box_table.sv
// Box table memory: one write port and one read port with registered data.
// Depends on apr_pkg for the box word.
`timescale 1ns / 1ps

module apr_box_table #(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6
) (
    input  logic              clk,
    input  logic              wen,
    input  logic [IDX_W-1:0]  waddr,
    input  apr_pkg::box_t     wdata,
    input  logic [IDX_W-1:0]  raddr,
    output apr_pkg::box_t     rdata
);

    apr_pkg::box_t mem_reg [DEPTH];
    apr_pkg::box_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/apr_push_unit.sv
// Shared push-out datapath, stepped once per box through bounds, span,
// overlap, pick and move; holds the player position between boxes.
// Depends on apr_pkg for the control group and the box word.
`timescale 1ns / 1ps

module apr_push_unit (
    input  logic                    clk,
    input  apr_pkg::ctrl_t          ctrl,
    input  logic signed [31:0]      load_x,
    input  logic signed [31:0]      load_y,
    input  logic signed [31:0]      load_z,
    input  logic [20:0]             radius,
    input  logic [20:0]             height,
    input  apr_pkg::box_t           box,
    output logic                    hit,
    output logic signed [31:0]      res_x,
    output logic signed [31:0]      res_z
);

    localparam int DW = apr_pkg::DW;

    typedef logic signed [DW-1:0] dw_t;

    localparam dw_t EPS = dw_t'(apr_pkg::EPS_Q);

    logic signed [31:0] px_reg;
    logic signed [31:0] pz_reg;
    logic signed [31:0] cx_reg;
    logic signed [31:0] cz_reg;
    dw_t pminy_reg;
    dw_t pmaxy_reg;
    dw_t ey0_reg;
    dw_t ey1_reg;
    dw_t bx0_reg;
    dw_t bx1_reg;
    dw_t bz0_reg;
    dw_t bz1_reg;
    dw_t ax0_reg;
    dw_t ax1_reg;
    dw_t az0_reg;
    dw_t az1_reg;
    dw_t lox_reg;
    dw_t hix_reg;
    dw_t loz_reg;
    dw_t hiz_reg;
    dw_t ox_reg;
    dw_t oz_reg;
    dw_t amt_reg;
    logic yhit_reg;
    logic negx_reg;
    logic negz_reg;
    logic hit_reg;
    logic selx_reg;

    dw_t  mv_tgt;
    dw_t  mv_sum;
    logic mv_neg;
    logic signed [31:0] mv_sat;

    function automatic dw_t sx(input logic signed [31:0] v);
        return DW'(v);
    endfunction

    function automatic dw_t ux(input logic [20:0] v);
        return $signed(DW'(v));
    endfunction

    function automatic logic signed [31:0] sat32(input dw_t v);
        logic signed [31:0] r;
        r = v[31:0];
        if (!(&v[DW-1:31]) && (|v[DW-1:31]))
        begin
            r = v[DW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

    always_comb
    begin
        mv_tgt = selx_reg ? sx(px_reg) : sx(pz_reg);
        mv_neg = selx_reg ? negx_reg : negz_reg;
        mv_sum = mv_neg ? (mv_tgt - amt_reg) : (mv_tgt + amt_reg);
        mv_sat = sat32(mv_sum);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            px_reg    <= load_x;
            pz_reg    <= load_z;
            pminy_reg <= sx(load_y) - ux(height) + EPS;
            pmaxy_reg <= sx(load_y) - EPS;
        end
        case (ctrl.step)
            apr_pkg::ST_BOUND:
            begin
                cx_reg  <= box.centre_x;
                cz_reg  <= box.centre_z;
                ey0_reg <= sx(box.bottom_y);
                ey1_reg <= sx(box.bottom_y) + ux(box.extent_y);
                bx0_reg <= sx(box.centre_x) - ux(box.extent_x >> 1);
                bx1_reg <= sx(box.centre_x) + ux(box.extent_x >> 1);
                bz0_reg <= sx(box.centre_z) - ux(box.extent_z >> 1);
                bz1_reg <= sx(box.centre_z) + ux(box.extent_z >> 1);
                ax0_reg <= sx(px_reg) - ux(radius) + EPS;
                ax1_reg <= sx(px_reg) + ux(radius) - EPS;
                az0_reg <= sx(pz_reg) - ux(radius) + EPS;
                az1_reg <= sx(pz_reg) + ux(radius) - EPS;
            end
            apr_pkg::ST_SPAN:
            begin
                yhit_reg <= (pminy_reg < ey1_reg) && (pmaxy_reg > ey0_reg);
                lox_reg  <= (ax0_reg > bx0_reg) ? ax0_reg : bx0_reg;
                hix_reg  <= (ax1_reg < bx1_reg) ? ax1_reg : bx1_reg;
                loz_reg  <= (az0_reg > bz0_reg) ? az0_reg : bz0_reg;
                hiz_reg  <= (az1_reg < bz1_reg) ? az1_reg : bz1_reg;
                negx_reg <= px_reg < cx_reg;
                negz_reg <= pz_reg < cz_reg;
            end
            apr_pkg::ST_OVLP:
            begin
                ox_reg  <= hix_reg - lox_reg;
                oz_reg  <= hiz_reg - loz_reg;
                hit_reg <= yhit_reg && (hix_reg > lox_reg) && (hiz_reg > loz_reg);
            end
            apr_pkg::ST_PICK:
            begin
                selx_reg <= ox_reg < oz_reg;
                amt_reg  <= ((ox_reg < oz_reg) ? ox_reg : oz_reg) + EPS;
            end
            apr_pkg::ST_MOVE:
            begin
                if (hit_reg)
                begin
                    if (selx_reg)
                    begin
                        px_reg <= mv_sat;
                    end
                    else
                    begin
                        pz_reg <= mv_sat;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign hit   = hit_reg;
    assign res_x = px_reg;
    assign res_z = pz_reg;

endmodule

### rtl/aabb_pushout_resolver.sv
// Top level of the box push-out resolver: handshake, configuration, table
// count and the pass/box sequencer. Uses apr_pkg, apr_box_table, apr_push_unit.
//
//   Channel   Direction  Handshake              Payload
//   input     in         in_valid / in_ready    cmd, pos_x, pos_y, pos_z, box_*
//   result    out        out_valid / out_ready  new_x, new_z, moved
//   config    in         cfg_wen                cfg_addr, cfg_wdata
//
// An append or a clear gives no result.
// A resolve makes P passes over the N stored boxes, P at most MAX_PASSES;
// the shared datapath spends six steps on each box.
// Reset clears state and count, presets radius and height; the table is not swept.
// A finished result sits in the output register; a new item is taken meanwhile,
// and the next resolve holds its result back until the previous one is taken.
`timescale 1ns / 1ps

module aabb_pushout_resolver #(
    parameter int MAX_BOXES  = 64,
    parameter int MAX_PASSES = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         cmd,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic [20:0]        box_width,
    input  logic [20:0]        box_length,
    input  logic [20:0]        box_height,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] new_x,
    output logic signed [31:0] new_z,
    output logic               moved,
    input  logic               cfg_wen,
    input  logic [0:0]         cfg_addr,
    input  logic [20:0]        cfg_wdata
);

    localparam int IDX_W  = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CNT_W  = $clog2(MAX_BOXES + 1);
    localparam int PASS_W = (MAX_PASSES > 1) ? $clog2(MAX_PASSES) : 1;

    apr_pkg::step_t     state_reg;
    apr_pkg::step_t     state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;
    logic [PASS_W-1:0]  pass_reg;
    logic [PASS_W-1:0]  pass_next;
    logic               any_reg;
    logic               any_next;
    logic               moved_reg;
    logic               moved_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [20:0]        radius_reg;
    logic [20:0]        height_reg;
    logic signed [31:0] new_x_reg;
    logic signed [31:0] new_z_reg;
    logic               out_moved_reg;

    logic               in_acc;
    logic               room;
    logic               tbl_wen;
    logic               res_load;
    logic               last_box;
    logic               any_now;
    apr_pkg::box_t      wr_box;
    apr_pkg::box_t      rd_box;
    apr_pkg::ctrl_t     ctrl;
    logic               hit;
    logic signed [31:0] res_x;
    logic signed [31:0] res_z;

    assign in_ready = (state_reg == apr_pkg::ST_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign room     = count_reg < CNT_W'(MAX_BOXES);
    assign tbl_wen  = in_acc && (cmd == apr_pkg::CMD_APPEND) && room;

    assign wr_box.centre_x = pos_x;
    assign wr_box.bottom_y = pos_y;
    assign wr_box.centre_z = pos_z;
    assign wr_box.extent_x = box_width;
    assign wr_box.extent_z = box_length;
    assign wr_box.extent_y = box_height;

    assign ctrl.step = state_reg;
    assign ctrl.load = in_acc && (cmd == apr_pkg::CMD_RESOLVE);

    assign last_box = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;
    assign any_now  = any_reg || hit;

    apr_box_table #(
        .DEPTH (MAX_BOXES),
        .IDX_W (IDX_W)
    ) u_table (
        .clk   (clk),
        .wen   (tbl_wen),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (wr_box),
        .raddr (idx_reg),
        .rdata (rd_box)
    );

    apr_push_unit u_push (
        .clk    (clk),
        .ctrl   (ctrl),
        .load_x (pos_x),
        .load_y (pos_y),
        .load_z (pos_z),
        .radius (radius_reg),
        .height (height_reg),
        .box    (rd_box),
        .hit    (hit),
        .res_x  (res_x),
        .res_z  (res_z)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        pass_next      = pass_reg;
        any_next       = any_reg;
        moved_next     = moved_reg;
        out_valid_next = out_valid_reg && !out_ready;
        res_load       = 1'b0;
        case (state_reg)
            apr_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    case (cmd)
                        apr_pkg::CMD_APPEND:
                        begin
                            if (room)
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        apr_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        apr_pkg::CMD_RESOLVE:
                        begin
                            idx_next   = '0;
                            pass_next  = '0;
                            any_next   = 1'b0;
                            moved_next = 1'b0;
                            state_next = (count_reg == '0) ? apr_pkg::ST_DONE
                                                           : apr_pkg::ST_FETCH;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            apr_pkg::ST_FETCH: state_next = apr_pkg::ST_BOUND;
            apr_pkg::ST_BOUND: state_next = apr_pkg::ST_SPAN;
            apr_pkg::ST_SPAN:  state_next = apr_pkg::ST_OVLP;
            apr_pkg::ST_OVLP:  state_next = apr_pkg::ST_PICK;
            apr_pkg::ST_PICK:  state_next = apr_pkg::ST_MOVE;
            apr_pkg::ST_MOVE:
            begin
                moved_next = moved_reg || hit;
                state_next = apr_pkg::ST_FETCH;
                if (!last_box)
                begin
                    idx_next = idx_reg + IDX_W'(1);
                    any_next = any_now;
                end
                else if (!any_now || (pass_reg == PASS_W'(MAX_PASSES - 1)))
                begin
                    state_next = apr_pkg::ST_DONE;
                end
                else
                begin
                    idx_next  = '0;
                    pass_next = pass_reg + PASS_W'(1);
                    any_next  = 1'b0;
                end
            end
            apr_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    res_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = apr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = apr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= apr_pkg::ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            pass_reg      <= '0;
            any_reg       <= 1'b0;
            moved_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            pass_reg      <= pass_next;
            any_reg       <= any_next;
            moved_reg     <= moved_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= apr_pkg::RADIUS_RESET;
            height_reg <= apr_pkg::HEIGHT_RESET;
        end
        else if (cfg_wen)
        begin
            case (cfg_addr)
                apr_pkg::REG_RADIUS: radius_reg <= cfg_wdata;
                apr_pkg::REG_HEIGHT: height_reg <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            new_x_reg     <= res_x;
            new_z_reg     <= res_z;
            out_moved_reg <= moved_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign new_x     = new_x_reg;
    assign new_z     = new_z_reg;
    assign moved     = out_moved_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_BOXES))
        else $error("Box count has passed the table capacity.");

    a_fetch_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == apr_pkg::ST_FETCH) |-> (CNT_W'(idx_reg) < count_reg))
        else $error("A box beyond the stored count is being fetched.");

    a_done_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == apr_pkg::ST_DONE) && (!out_valid_reg || out_ready)
        |=> out_valid_reg && (state_reg == apr_pkg::ST_IDLE))
        else $error("A finished resolve did not present its result beat.");

    a_moved_from_hit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(moved_reg) |-> $past(state_reg == apr_pkg::ST_MOVE && hit))
        else $error("The moved flag was set without a push.");

endmodule

### tb/sv/tb_aabb_pushout_resolver.sv
// Self-checking bench for aabb_pushout_resolver: a directed table, then random box/resolve
// episodes under several idling regimes, checked against an in-bench push-out predictor.
// Depends on apr_pkg and the resolver RTL only.
`timescale 1ns / 1ps

module tb_aabb_pushout_resolver;

    localparam logic [1:0]  CMD_APPEND   = apr_pkg::CMD_APPEND;
    localparam logic [1:0]  CMD_CLEAR    = apr_pkg::CMD_CLEAR;
    localparam logic [1:0]  CMD_RESOLVE  = apr_pkg::CMD_RESOLVE;
    localparam logic [0:0]  REG_RADIUS   = apr_pkg::REG_RADIUS;
    localparam logic [0:0]  REG_HEIGHT   = apr_pkg::REG_HEIGHT;
    localparam logic [20:0] RADIUS_RESET = apr_pkg::RADIUS_RESET;
    localparam logic [20:0] HEIGHT_RESET = apr_pkg::HEIGHT_RESET;
    localparam int          EPS_Q        = apr_pkg::EPS_Q;

    localparam int  CLK_PERIOD   = 4;
    localparam int  TABLE_DEPTH  = 64;
    localparam int  PASS_LIMIT   = 4;
    localparam int  UNIT         = 65536;
    localparam int  PHASE_BEATS  = 250;
    localparam int  DRAIN_CYCLES = 1600;
    localparam int  HOLD_CYCLES  = 3000;
    localparam int  TIMEOUT_NS   = 40_000_000;
    localparam logic [1:0]  CMD_UNUSED = 2'd3;
    localparam logic [20:0] EXT_MAX    = 21'h100000;
    localparam longint Q16_MAX = 2147483647;
    localparam longint Q16_MIN = -longint'(2147483647) - 1;

    typedef struct packed {
        logic [1:0]  cmd;
        int          x;
        int          y;
        int          z;
        logic [20:0] w;
        logic [20:0] l;
        logic [20:0] h;
    } beat_t;

    typedef struct packed {
        int x;
        int z;
        bit moved;
    } pose_t;

    typedef struct packed {
        int          cx;
        int          by;
        int          cz;
        logic [20:0] ex;
        logic [20:0] ez;
        logic [20:0] ey;
    } box_entry_t;

    typedef struct packed {
        beat_t b;
        bit    typed;
        pose_t want;
    } row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         cmd;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [20:0]        box_width;
    logic [20:0]        box_length;
    logic [20:0]        box_height;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] new_x;
    logic signed [31:0] new_z;
    logic               moved;
    logic               cfg_wen;
    logic [0:0]         cfg_addr;
    logic [20:0]        cfg_wdata;

    box_entry_t  box_table[TABLE_DEPTH];
    int          box_total;
    logic [20:0] model_radius;
    logic [20:0] model_height;
    pose_t       pending_poses[$];
    int          fault_count = 0;
    int          hold_left = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    aabb_pushout_resolver #(
        .MAX_BOXES  (TABLE_DEPTH),
        .MAX_PASSES (PASS_LIMIT)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .box_width  (box_width),
        .box_length (box_length),
        .box_height (box_height),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .new_x      (new_x),
        .new_z      (new_z),
        .moved      (moved),
        .cfg_wen    (cfg_wen),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic longint clamp_q16(input longint v);
        if (v > Q16_MAX)
        begin
            return Q16_MAX;
        end
        if (v < Q16_MIN)
        begin
            return Q16_MIN;
        end
        return v;
    endfunction

    // Updates the box table for appends and clears; for a resolve, computes the pushed-out pose.
    function automatic bit predict_pushout(input beat_t b, output pose_t r);
        longint px, pz, pr, ylo, yhi, ey0, ey1, cx, cz, hx, hz;
        longint ax0, ax1, az0, az1, bx0, bx1, bz0, bz1, ox, oz;
        bit     any;
        bit     shifted;
        int     pass_no;
        r = '0;
        predict_pushout = 1'b0;
        case (b.cmd)
            CMD_APPEND:
            begin
                if (box_total < TABLE_DEPTH)
                begin
                    box_table[box_total].cx = b.x;
                    box_table[box_total].by = b.y;
                    box_table[box_total].cz = b.z;
                    box_table[box_total].ex = b.w;
                    box_table[box_total].ez = b.l;
                    box_table[box_total].ey = b.h;
                    box_total++;
                end
            end
            CMD_CLEAR:
            begin
                box_total = 0;
            end
            CMD_RESOLVE:
            begin
                px = $signed(b.x);
                pz = $signed(b.z);
                pr = longint'(model_radius);
                ylo = longint'($signed(b.y)) - longint'(model_height) + EPS_Q;
                yhi = longint'($signed(b.y)) - EPS_Q;
                shifted = 1'b0;
                any = 1'b1;
                pass_no = 0;
                while (any && pass_no < PASS_LIMIT && box_total > 0)
                begin
                    any = 1'b0;
                    for (int i = 0; i < box_total; i++)
                    begin
                        ey0 = $signed(box_table[i].by);
                        ey1 = ey0 + longint'(box_table[i].ey);
                        cx = $signed(box_table[i].cx);
                        cz = $signed(box_table[i].cz);
                        hx = longint'(box_table[i].ex >> 1);
                        hz = longint'(box_table[i].ez >> 1);
                        ax0 = px - pr + EPS_Q;
                        ax1 = px + pr - EPS_Q;
                        az0 = pz - pr + EPS_Q;
                        az1 = pz + pr - EPS_Q;
                        bx0 = cx - hx;
                        bx1 = cx + hx;
                        bz0 = cz - hz;
                        bz1 = cz + hz;
                        if (yhi > ey0 && ylo < ey1 && ax1 > bx0 && ax0 < bx1
                            && az1 > bz0 && az0 < bz1)
                        begin
                            ox = ((ax1 < bx1) ? ax1 : bx1) - ((ax0 > bx0) ? ax0 : bx0);
                            oz = ((az1 < bz1) ? az1 : bz1) - ((az0 > bz0) ? az0 : bz0);
                            if (ox > 0 && oz > 0)
                            begin
                                if (ox < oz)
                                begin
                                    px = clamp_q16((px < cx) ? px - (ox + EPS_Q)
                                                             : px + (ox + EPS_Q));
                                end
                                else
                                begin
                                    pz = clamp_q16((pz < cz) ? pz - (oz + EPS_Q)
                                                             : pz + (oz + EPS_Q));
                                end
                                any = 1'b1;
                                shifted = 1'b1;
                            end
                        end
                    end
                    pass_no++;
                end
                r.x = int'(px);
                r.z = int'(pz);
                r.moved = shifted;
                predict_pushout = 1'b1;
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic beat_t pack_beat(input logic [1:0] c, input int x, input int y,
                                        input int z, input logic [20:0] w,
                                        input logic [20:0] l, input logic [20:0] h);
        beat_t b;
        b.cmd = c;
        b.x = x;
        b.y = y;
        b.z = z;
        b.w = w;
        b.l = l;
        b.h = h;
        return b;
    endfunction

    function automatic row_t make_row(input beat_t b, input bit typed, input int wx,
                                      input int wz, input bit wm);
        row_t r;
        r.b = b;
        r.typed = typed;
        r.want.x = wx;
        r.want.z = wz;
        r.want.moved = wm;
        return r;
    endfunction

    function automatic int pick_base();
        case ($urandom_range(7))
            0: return $urandom;
            1: return 32'sh7FFC0000;
            2: return 32'sh80040000;
            default: return int'($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000;
        endcase
    endfunction

    function automatic int near(input int base, input int span);
        return base + int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic logic [20:0] pick_extent();
        case ($urandom_range(9))
            0: return '0;
            1: return EXT_MAX;
            2: return 21'($urandom_range(0, EXT_MAX));
            default: return 21'($urandom_range(UNIT / 4, 3 * UNIT));
        endcase
    endfunction

    task automatic offer_beat(input beat_t b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= b.cmd;
        pos_x <= b.x;
        pos_y <= b.y;
        pos_z <= b.z;
        box_width <= b.w;
        box_length <= b.l;
        box_height <= b.h;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_beat(input beat_t b);
        pose_t p;
        offer_beat(b);
        if (predict_pushout(b, p))
        begin
            pending_poses = {pending_poses, p};
        end
    endtask

    task automatic settle();
        while (pending_poses.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (16) @(posedge clk);
    endtask

    task automatic write_regs(input logic [20:0] radius, input logic [20:0] height);
        cfg_wen <= 1'b1;
        cfg_addr <= REG_RADIUS;
        cfg_wdata <= radius;
        @(posedge clk);
        cfg_addr <= REG_HEIGHT;
        cfg_wdata <= height;
        @(posedge clk);
        cfg_wen <= 1'b0;
        model_radius = radius;
        model_height = height;
    endtask

    // Each episode builds a cluster of boxes around one base point and then
    // resolves player positions inside that cluster, with stray beats mixed in.
    task automatic run_phase(input int quota);
        int    done;
        int    boxes;
        int    asks;
        int    bx, by, bz;
        beat_t b;
        done = 0;
        while (done < quota)
        begin
            bx = pick_base();
            by = pick_base();
            bz = pick_base();
            boxes = ($urandom_range(15) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 8);
            asks = $urandom_range(1, 6);
            if ($urandom_range(3) != 0)
            begin
                send_beat(pack_beat(CMD_CLEAR, $urandom, $urandom, $urandom,
                                    pick_extent(), pick_extent(), pick_extent()));
                done++;
            end
            for (int k = 0; k < boxes + asks; k++)
            begin
                if ($urandom_range(9) == 0)
                begin
                    b = pack_beat(2'($urandom_range(3)), $urandom, $urandom, $urandom,
                                  pick_extent(), pick_extent(), pick_extent());
                    send_beat(b);
                    if (b.cmd != CMD_UNUSED)
                    begin
                        done++;
                    end
                end
                if (k < boxes)
                begin
                    b = pack_beat(CMD_APPEND, near(bx, 4 * UNIT), near(by, 2 * UNIT),
                                  near(bz, 4 * UNIT), pick_extent(), pick_extent(),
                                  pick_extent());
                end
                else
                begin
                    b = pack_beat(CMD_RESOLVE, near(bx, 4 * UNIT),
                                  by + int'($urandom_range(0, 3 * UNIT)), near(bz, 4 * UNIT),
                                  pick_extent(), pick_extent(), pick_extent());
                end
                send_beat(b);
                done++;
            end
        end
    endtask

    always @(posedge clk)
    begin : result_check
        pose_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_poses.size() == 0)
            begin
                $display("%0t: unexpected result beat: new_x %0d new_z %0d moved %0b",
                         $time, new_x, new_z, moved);
                fault_count++;
            end
            else
            begin
                want = pending_poses.pop_front();
                if (new_x !== want.x)
                begin
                    $display("%0t: new_x mismatch: expected %0d, got %0d",
                             $time, want.x, new_x);
                    fault_count++;
                end
                if (new_z !== want.z)
                begin
                    $display("%0t: new_z mismatch: expected %0d, got %0d",
                             $time, want.z, new_z);
                    fault_count++;
                end
                if (moved !== want.moved)
                begin
                    $display("%0t: moved mismatch: expected %0b, got %0b",
                             $time, want.moved, moved);
                    fault_count++;
                end
            end
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (rst_n)
        begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : stimulus
        row_t  plan[$];
        pose_t got;
        in_valid <= 1'b0;
        cmd <= CMD_CLEAR;
        pos_x <= '0;
        pos_y <= '0;
        pos_z <= '0;
        box_width <= '0;
        box_length <= '0;
        box_height <= '0;
        out_ready <= 1'b0;
        cfg_wen <= 1'b0;
        cfg_addr <= REG_RADIUS;
        cfg_wdata <= '0;
        model_radius = RADIUS_RESET;
        model_height = HEIGHT_RESET;
        box_total = 0;

        plan = {plan, make_row(pack_beat(CMD_RESOLVE, 32'sh80000000, 0, 32'sh7FFFFFFF,
                                          '0, '0, '0), 1'b1, 32'sh80000000, 32'sh7FFFFFFF, 1'b0)};
        plan = {plan, make_row(pack_beat(CMD_RESOLVE, 32'sh7FFFFFFF, 32'sh80000000,
                                          32'sh80000000, EXT_MAX, EXT_MAX, EXT_MAX),
                                1'b1, 32'sh7FFFFFFF, 32'sh80000000, 1'b0)};
        plan = {plan, make_row(pack_beat(CMD_UNUSED, -1, -1, -1, EXT_MAX, EXT_MAX, EXT_MAX),
                                1'b0, 0, 0, 1'b0)};
        plan = {plan, make_row(pack_beat(CMD_APPEND, 0, 0, 0, '0, '0, '0), 1'b0, 0, 0, 1'b0)};
        plan = {plan, make_row(pack_beat(CMD_RESOLVE, 0, UNIT, 0, '0, '0, '0),
                                1'b1, 0, 0, 1'b0)};
        plan = {plan, make_row(pack_beat(CMD_CLEAR, 0, 0, 0, '0, '0, '0), 1'b0, 0, 0, 1'b0)};
        plan = {plan, make_row(pack_beat(CMD_APPEND, 0, 0, 0, UNIT, UNIT, UNIT),
                                1'b0, 0, 0, 1'b0)};
        plan = {plan, make_row(pack_beat(CMD_RESOLVE, 0, 3 * UNIT / 2, 0, '0, '0, '0),
                                1'b0, 0, 0, 1'b0)};
        plan = {plan, make_row(pack_beat(CMD_RESOLVE, -20000, 3 * UNIT / 2, 0, '0, '0, '0),
                                1'b0, 0, 0, 1'b0)};
        plan = {plan, make_row(pack_beat(CMD_RESOLVE, 0, 3 * UNIT / 2, -30000, '0, '0, '0),
                                1'b0, 0, 0, 1'b0)};
        plan = {plan, make_row(pack_beat(CMD_RESOLVE, -10000, 3 * UNIT / 2, -10000,
                                          '0, '0, '0), 1'b0, 0, 0, 1'b0)};
        plan = {plan, make_row(pack_beat(CMD_RESOLVE, 0, 4 * UNIT, 0, '0, '0, '0),
                                1'b0, 0, 0, 1'b0)};
        plan = {plan, make_row(pack_beat(CMD_APPEND, 0, 0, 3 * UNIT / 4, UNIT, UNIT, UNIT),
                                1'b0, 0, 0, 1'b0)};
        plan = {plan, make_row(pack_beat(CMD_RESOLVE, 0, 3 * UNIT / 2, UNIT / 2, '0, '0, '0),
                                1'b0, 0, 0, 1'b0)};
        plan = {plan, make_row(pack_beat(CMD_CLEAR, 0, 0, 0, '0, '0, '0), 1'b0, 0, 0, 1'b0)};
        plan = {plan, make_row(pack_beat(CMD_APPEND, 32'sh7FFF0000, 0, 0, 2 * UNIT,
                                          EXT_MAX, EXT_MAX), 1'b0, 0, 0, 1'b0)};
        plan = {plan, make_row(pack_beat(CMD_RESOLVE, 32'sh7FFFFF00, UNIT, 0, '0, '0, '0),
                                1'b0, 0, 0, 1'b0)};
        plan = {plan, make_row(pack_beat(CMD_CLEAR, 0, 0, 0, '0, '0, '0), 1'b0, 0, 0, 1'b0)};
        plan = {plan, make_row(pack_beat(CMD_APPEND, 32'sh80010000, 0, 0, 2 * UNIT,
                                          EXT_MAX, EXT_MAX), 1'b0, 0, 0, 1'b0)};
        plan = {plan, make_row(pack_beat(CMD_RESOLVE, 32'sh80000100, UNIT, 0, '0, '0, '0),
                                1'b0, 0, 0, 1'b0)};
        plan = {plan, make_row(pack_beat(CMD_APPEND, -1, -1, -1, 21'h0FFFFF, 21'h0FFFFF,
                                          21'h0FFFFF), 1'b0, 0, 0, 1'b0)};
        plan = {plan, make_row(pack_beat(CMD_RESOLVE, -1, UNIT - 1, -1, '0, '0, '0),
                                1'b0, 0, 0, 1'b0)};
        plan = {plan, make_row(pack_beat(CMD_CLEAR, 0, 0, 0, '0, '0, '0), 1'b0, 0, 0, 1'b0)};
        plan = {plan, make_row(pack_beat(CMD_RESOLVE, 32'sh55555555, 0, 32'shAAAAAAAA,
                                          '0, '0, '0), 1'b1, 32'sh55555555, 32'shAAAAAAAA, 1'b0)};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            offer_beat(plan[i].b);
            if (predict_pushout(plan[i].b, got))
            begin
                pending_poses = {pending_poses, (plan[i].typed ? plan[i].want : got)};
            end
        end
        in_valid <= 1'b0;

        for (int ph = 0; ph < 5; ph++)
        begin
            settle();
            case (ph)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    write_regs(EXT_MAX, EXT_MAX);
                    send_idle_pct = 86;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    write_regs('0, '0);
                    send_idle_pct = 0;
                    recv_stall_pct = 86;
                end
                3:
                begin
                    write_regs(21'($urandom_range(0, EXT_MAX)), 21'($urandom_range(0, EXT_MAX)));
                    send_idle_pct = 13;
                    recv_stall_pct = 13;
                end
                default:
                begin
                    write_regs(RADIUS_RESET, HEIGHT_RESET);
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                    // The receiver stops taking results for a long stretch so that the
                    // output register and the sequencer back up into the input.
                    @(negedge clk);
                    hold_left = HOLD_CYCLES;
                    @(posedge clk);
                end
            endcase
            run_phase(PHASE_BEATS);
            in_valid <= 1'b0;
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fault_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
